// ===== sv/sasum_pkg.sv =====
`default_nettype none
package sasum_pkg;
	localparam int COUNT_BITS_DEF = 24;
	localparam int STRIDE_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 32;
	localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_COUNT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE = 1'd1;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam int QUEUE_DEPTH = 2;

	// kind of queued item
	typedef enum logic [1:0] {
		OP_ZERO = 2'd0,
		OP_ADD = 2'd1,
		OP_ADD_LAST = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [31:0] word;
	} task_t;

	function automatic logic is_nan(input logic [31:0] b);
		is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// add two non-negative finite/inf floats, round to nearest even
	function automatic logic [31:0] fadd_pos(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x, y, r;
		logic [7:0] ex, ey, e;
		logic [26:0] mx, my, s2;
		logic [27:0] s;
		logic [7:0] d;
		logic st;
		logic [23:0] m;
		logic rb;
		logic [24:0] mr;
		logic [8:0] en;
		if (a[30:0] >= b[30:0]) begin
			x = a; y = b;
		end else begin
			x = b; y = a;
		end
		ex = x[30:23]; ey = y[30:23];
		r = 32'd0;
		mx = {(ex != 8'd0), x[22:0], 3'b000};
		my = {(ey != 8'd0), y[22:0], 3'b000};
		if (ex == 8'd0) ex = 8'd1;
		if (ey == 8'd0) ey = 8'd1;
		d = ex - ey;
		if (x[30:23] == 8'hFF) begin
			r = 32'h7F80_0000;
		end else begin
			if (d >= 8'd27) begin
				st = (my != 27'd0);
				my = {26'd0, st};
			end else begin
				st = ((my & ((27'd1 << d) - 27'd1)) != 27'd0);
				my = (my >> d) | {26'd0, st};
			end
			s = {1'b0, mx} + {1'b0, my};
			e = ex;
			if (s[27]) begin
				s2 = s[27:1] | {26'd0, s[0]};
				en = {1'b0, e} + 9'd1;
			end else begin
				s2 = s[26:0];
				en = {1'b0, e};
				// both operands non-negative: no cancellation, only subnormal sums
				if (!s2[26] && e == 8'd1) en = 9'd0;
			end
			m = s2[26:3];
			rb = s2[2] && (s2[1] || s2[0] || m[0]);
			mr = {1'b0, m} + {24'd0, rb};
			if (mr[24]) begin
				en = en + 9'd1;
				mr = mr >> 1;
			end else if (en == 9'd0 && mr[23]) begin
				en = 9'd1;
			end
			if (en >= 9'd255) r = 32'h7F80_0000;
			else r = {1'b0, en[7:0], mr[22:0]};
		end
		fadd_pos = r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/sasum_if.sv =====
`default_nettype none
interface sasum_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] bits;
	modport source(output valid, output bits, input ready);
	modport sink(input valid, input bits, output ready);
endinterface
`default_nettype wire

// ===== sv/strided_abs_sum_fp32.sv =====
// channel | dir | payload
// in_ch   | in  | value_bits [31:0]
// out_ch  | out | sum_bits [31:0]
// One word per cycle unless the output stalls; the combinational FP add in
// the back end closes the accumulator loop; each sum is registered in out_q.
// arst_n clears counters, accumulator, queue pointers; stride resets to 1.
// A stalled output fills the two-entry queue, then in_ch.ready drops.
`default_nettype none
module strided_abs_sum_fp32 #(
	parameter int COUNT_BITS = sasum_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sasum_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input wire logic [sasum_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sasum_if.sink in_ch,
	sasum_if.source out_ch
);
	sasum_pkg::task_t wr_task, rd_task;
	logic push, full, ne, pop;

	sasum_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_ch,
		.task_o(wr_task), .task_push(push), .task_full(full));
	sasum_queue u_queue (.clk, .arst_n, .wr_data(wr_task), .push, .full,
		.rd_data(rd_task), .not_empty(ne), .pop);
	sasum_back u_back (.clk, .arst_n, .task_i(rd_task), .task_valid(ne),
		.task_pop(pop), .out_ch);
endmodule
`default_nettype wire

// ===== sv/sasum_front.sv =====
`default_nettype none
module sasum_front #(
	parameter int COUNT_BITS = sasum_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sasum_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input wire logic [sasum_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sasum_if.sink in_ch,
	output sasum_pkg::task_t task_o,
	output logic task_push,
	input wire logic task_full
);
	logic [COUNT_BITS-1:0] count_q, taken_q;
	logic [sasum_pkg::STRIDE_BITS-1:0] stride_q, skip_q;
	logic acc;

	assign in_ch.ready = !task_full;
	assign acc = in_ch.valid && in_ch.ready;

	always_comb begin
		task_o.word = {1'b0, in_ch.bits[30:0]};
		task_push = 1'b0;
		task_o.op = sasum_pkg::OP_ADD;
		if (count_q == '0 || stride_q == '0) begin
			task_o.op = sasum_pkg::OP_ZERO;
			task_push = acc;
		end else if (skip_q == '0) begin
			task_push = acc;
			task_o.op = (taken_q + 1'b1 >= count_q) ? sasum_pkg::OP_ADD_LAST
				: sasum_pkg::OP_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			stride_q <= 16'd1;
			taken_q <= '0;
			skip_q <= '0;
		end else begin
			if (cfg_we && cfg_index == sasum_pkg::REG_ELEMENT_COUNT)
				count_q <= cfg_data[COUNT_BITS-1:0];
			if (cfg_we && cfg_index == sasum_pkg::REG_STRIDE)
				stride_q <= cfg_data[sasum_pkg::STRIDE_BITS-1:0];
			if (acc) begin
				if (task_o.op == sasum_pkg::OP_ZERO) begin
					taken_q <= '0;
					skip_q <= '0;
				end else if (skip_q != '0) begin
					skip_q <= skip_q - 1'b1;
				end else if (task_o.op == sasum_pkg::OP_ADD_LAST) begin
					taken_q <= '0;
					skip_q <= '0;
				end else begin
					taken_q <= taken_q + 1'b1;
					skip_q <= stride_q - 1'b1;
				end
			end
		end
	end

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		task_push |-> !task_full) else $error("push into full queue");
	a_skip_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && skip_q != '0 && count_q != '0 && stride_q != '0) |-> !task_push)
		else $error("skipped word pushed");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(task_push && task_o.op == sasum_pkg::OP_ADD_LAST) |=> taken_q == '0)
		else $error("count not cleared");
endmodule
`default_nettype wire

// ===== sv/sasum_queue.sv =====
`default_nettype none
module sasum_queue (
	input wire logic clk,
	input wire logic arst_n,
	input sasum_pkg::task_t wr_data,
	input wire logic push,
	output logic full,
	output sasum_pkg::task_t rd_data,
	output logic not_empty,
	input wire logic pop
);
	sasum_pkg::task_t mem_q [sasum_pkg::QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'(sasum_pkg::QUEUE_DEPTH);
	assign not_empty = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/sasum_back.sv =====
`default_nettype none
module sasum_back (
	input wire logic clk,
	input wire logic arst_n,
	input sasum_pkg::task_t task_i,
	input wire logic task_valid,
	output logic task_pop,
	sasum_if.source out_ch
);
	logic [31:0] acc_q, sum, out_q;
	logic out_v_q, emit;

	always_comb begin
		if (sasum_pkg::is_nan(acc_q) || sasum_pkg::is_nan(task_i.word)) sum = sasum_pkg::QNAN_BITS;
		else sum = sasum_pkg::fadd_pos(acc_q, task_i.word);
	end

	assign emit = task_i.op != sasum_pkg::OP_ADD;
	// hold the queue head while an emitting item finds the output slot taken
	assign task_pop = task_valid && (!emit || !out_v_q || out_ch.ready);
	assign out_ch.valid = out_v_q;
	assign out_ch.bits = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_ch.ready) out_v_q <= 1'b0;
			if (task_pop) begin
				unique case (task_i.op)
					sasum_pkg::OP_ZERO: begin
						acc_q <= '0;
						out_v_q <= 1'b1;
					end
					sasum_pkg::OP_ADD_LAST: begin
						acc_q <= '0;
						out_v_q <= 1'b1;
					end
					default: acc_q <= sum;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (task_pop && emit) out_q <= (task_i.op == sasum_pkg::OP_ZERO) ? 32'd0 : sum;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> $stable(out_q)) else $error("result changed");
	a_acc_positive: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_q[31]) else $error("negative sum");
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(task_pop && emit) |=> acc_q == '0) else $error("acc not cleared");
endmodule
`default_nettype wire

// ===== test/sasum_tb_if.sv =====
// channel instances and clocking live in the testbench module itself

// ===== test/tb_strided_abs_sum_fp32.sv =====
module tb_strided_abs_sum_fp32;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {ROW_CFG, ROW_WORD} row_kind_t;
	typedef struct {
		row_kind_t kind;
		logic [sasum_pkg::CFG_IDX_BITS-1:0] idx;
		logic [31:0] data;
		bit typed;
		logic [31:0] sum;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sasum_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [sasum_pkg::CFG_DATA_BITS-1:0] cfg_data;

	sasum_if #(.W(sasum_pkg::WORD_BITS)) in_ch();
	sasum_if #(.W(sasum_pkg::WORD_BITS)) out_ch();

	strided_abs_sum_fp32 dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// shadow of the block's registers and vector state
	logic [23:0] want_count;
	logic [15:0] want_stride;
	logic [31:0] acc_bits;
	logic [23:0] taken;
	logic [15:0] skip_left;

	logic [31:0] sums_due[$];
	int errors = 0;
	int words_sent = 0;
	int sums_seen = 0;
	int stall_left = 0;
	bit quick = 0;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	function automatic bit nan_bits(input logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 23'd0;
	endfunction

	// round-to-nearest-even sum of two non-negative, non-NaN floats
	function automatic logic [31:0] add_nonneg(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] hi, lo;
		logic [63:0] mh, ml, s, m, rem, half;
		int eh, el, d, p, sh;
		logic [63:0] r;
		if (a[30:0] >= b[30:0]) begin
			hi = a; lo = b;
		end else begin
			hi = b; lo = a;
		end
		if (hi[30:23] == 8'hFF)
			return 32'h7F80_0000;
		eh = (hi[30:23] == 0) ? 1 : hi[30:23];
		el = (lo[30:23] == 0) ? 1 : lo[30:23];
		mh = {40'd0, hi[30:23] != 0, hi[22:0]};
		ml = {40'd0, lo[30:23] != 0, lo[22:0]};
		d = eh - el;
		// tiny addend below a quarter ulp cannot move the result
		if (d > 25)
			return hi;
		s = (mh << d) + ml;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (s[i]) p = i;
		if (p < 23)
			return s[31:0];
		sh = p - 23;
		m = s >> sh;
		if (sh > 0) begin
			rem = s & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && m[0]))
				m = m + 64'd1;
		end
		r = (64'(el + sh - 1) << 23) + m;
		if (r >= 64'h7F80_0000)
			return 32'h7F80_0000;
		return r[31:0];
	endfunction

	task automatic fold_word(input logic [31:0] w, output bit emits, output logic [31:0] s);
		logic [31:0] mag;
		mag = {1'b0, w[30:0]};
		emits = 0;
		s = 32'd0;
		if (want_count == 0 || want_stride == 0) begin
			acc_bits = 0; taken = 0; skip_left = 0;
			emits = 1;
		end else if (skip_left != 0) begin
			skip_left = skip_left - 1'b1;
		end else begin
			if (nan_bits(acc_bits) || nan_bits(mag))
				acc_bits = sasum_pkg::QNAN_BITS;
			else
				acc_bits = add_nonneg(acc_bits, mag);
			taken = taken + 1'b1;
			skip_left = want_stride - 1'b1;
			if (taken >= want_count) begin
				emits = 1;
				s = acc_bits;
				acc_bits = 0; taken = 0; skip_left = 0;
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: w = {w[31], 8'hFF, 23'd0};
			1: w = {w[31], 8'hFF, w[22:1], 1'b1};
			2: w = {w[31], 8'h00, w[22:0]};
			3: w = {w[31], 8'hFE, w[22:0]};
			4, 5, 6: w = {w[31], 8'(8'd120 + w[26:23]), w[22:0]};
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w, input bit typed, input logic [31:0] typed_sum);
		int g;
		bit emits;
		logic [31:0] s;
		g = quick ? 0 : pick_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.bits <= w;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
		fold_word(w, emits, s);
		if (emits)
			sums_due.push_back(typed ? typed_sum : s);
	endtask

	// hold input idle until every sum is out, then let skipped words settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sums_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sasum_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sasum_pkg::REG_ELEMENT_COUNT) want_count = v[23:0];
		else want_stride = v[15:0];
	endtask

	function automatic row_t cfg_row(input logic [sasum_pkg::CFG_IDX_BITS-1:0] i,
		input logic [31:0] v);
		return '{ROW_CFG, i, v, 0, 0};
	endfunction

	function automatic row_t word_row(input logic [31:0] w, input bit t, input logic [31:0] s);
		return '{ROW_WORD, 0, w, t, s};
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sums_seen++;
			if (sums_due.size() == 0) begin
				$error("sum_bits: no sum expected, actual %h", out_ch.bits);
				errors++;
			end else begin
				if (out_ch.bits !== sums_due[0]) begin
					$error("sum_bits: expected %h actual %h", sums_due[0], out_ch.bits);
					errors++;
				end
				void'(sums_due.pop_front());
			end
		end
	end

	initial begin
		int n_words;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.bits = '0;
		want_count = 0; want_stride = 1;
		acc_bits = 0; taken = 0; skip_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count is zero after reset: every word yields +0
		rows.push_back(word_row(32'hFFFF_FFFF, 1, 32'h0));
		rows.push_back(word_row(32'h3F80_0000, 1, 32'h0));
		rows.push_back(cfg_row(sasum_pkg::REG_ELEMENT_COUNT, 32'd3));
		rows.push_back(cfg_row(sasum_pkg::REG_STRIDE, 32'd0));
		rows.push_back(word_row(32'h1234_5678, 1, 32'h0));
		rows.push_back(cfg_row(sasum_pkg::REG_STRIDE, 32'd1));
		rows.push_back(word_row(32'hBF80_0000, 0, 0));
		rows.push_back(word_row(32'h4000_0000, 0, 0));
		rows.push_back(word_row(32'hC040_0000, 1, 32'h40C0_0000));
		rows.push_back(cfg_row(sasum_pkg::REG_ELEMENT_COUNT, 32'd2));
		rows.push_back(word_row(32'h7F7F_FFFF, 0, 0));
		rows.push_back(word_row(32'hFF7F_FFFF, 1, 32'h7F80_0000));
		rows.push_back(word_row(32'h7F80_0001, 0, 0));
		rows.push_back(word_row(32'h3F80_0000, 1, sasum_pkg::QNAN_BITS));
		rows.push_back(word_row(32'h0000_0001, 0, 0));
		rows.push_back(word_row(32'h8000_0001, 1, 32'h0000_0002));
		rows.push_back(word_row(32'hFF80_0000, 0, 0));
		rows.push_back(word_row(32'h3F80_0000, 1, 32'h7F80_0000));
		rows.push_back(cfg_row(sasum_pkg::REG_STRIDE, 32'd3));
		for (int i = 0; i < 4; i++) rows.push_back(word_row(32'h3F80_0000 + i, 0, 0));
		// widest count never completes until it is lowered mid-vector
		rows.push_back(cfg_row(sasum_pkg::REG_STRIDE, 32'd1));
		rows.push_back(cfg_row(sasum_pkg::REG_ELEMENT_COUNT, 32'hFFFF_FFFF));
		for (int i = 0; i < 3; i++) rows.push_back(word_row(32'h007F_FFFF << i, 0, 0));
		rows.push_back(cfg_row(sasum_pkg::REG_ELEMENT_COUNT, 32'd2));
		rows.push_back(word_row(32'h0080_0000, 0, 0));
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
			else send_word(rows[i].data, rows[i].typed, rows[i].sum);
		end

		for (int ph = 0; ph < 10; ph++) begin
			int r;
			r = $urandom_range(0, 9);
			if (r != 0) write_reg(sasum_pkg::REG_ELEMENT_COUNT, r == 1 ? 32'd0 :
				(r == 2 ? $urandom_range(20, 40) : $urandom_range(1, 8)));
			r = $urandom_range(0, 9);
			if (r != 0) write_reg(sasum_pkg::REG_STRIDE, r == 1 ? 32'd0 :
				(r == 2 ? $urandom_range(5, 9) : $urandom_range(1, 4)));
			n_words = $urandom_range(45, 65);
			for (int k = 0; k < n_words; k++) begin
				if (ph == 4 && k == 20) drain();
				send_word(pick_word(), 0, 0);
			end
		end

		// widest stride with a count of one: every word is a take and emits
		write_reg(sasum_pkg::REG_ELEMENT_COUNT, 32'd1);
		write_reg(sasum_pkg::REG_STRIDE, 32'hFFFF);
		quick = 1;
		for (int k = 0; k < 8; k++) send_word(pick_word(), 0, 0);
		quick = 0;
		send_word(pick_word(), 0, 0);
		drain();

		$display("covered %0d words and %0d sums over zero, small, large and widest settings",
			words_sent, sums_seen);
		if (errors == 0 && sums_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
